// ===== rtl/erm_pkg.sv =====
package erm_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int ENTRY_FRAC_BITS = 14;
  localparam int FIELD_BITS      = 16;
  localparam int ENTRY_BITS      = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int LANES           = 3;
  localparam int ENTRIES         = 9;
  localparam int CW              = 34;  // cordic datapath width
  localparam int PW              = 64;  // q60 product width

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
  };

  typedef logic [FIELD_BITS-1:0]        angle_t;
  typedef logic signed [ENTRY_BITS-1:0] entry_t;
  typedef logic signed [CW-1:0]         cw_t;
  typedef logic signed [PW-1:0]         prod_t;

  typedef struct packed {
    cw_t  x;
    cw_t  y;
    cw_t  z;
    logic flip;
  } lane_t;

  typedef struct packed {
    cw_t s;
    cw_t c;
  } sincos_t;

  // angle to a 32-bit turn, folded into [-quarter, +quarter)
  function automatic lane_t cordic_init(angle_t raw);
    logic [31:0] turn;
    lane_t       l;
    turn = 32'(raw);
    if (ANGLE_BITS < 32) begin
      turn = turn & ((32'd1 << ANGLE_BITS) - 32'd1);
    end
    turn   = turn << (32 - ANGLE_BITS);
    l.flip = turn[31] ^ turn[30];
    if (l.flip) begin
      turn[31] = ~turn[31];
    end
    l.x = CORDIC_GAIN;
    l.y = '0;
    l.z = CW'($signed(turn));
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, int i);
    cw_t   dx;
    cw_t   dy;
    cw_t   t;
    lane_t n;
    dx = l.y >>> i;
    dy = l.x >>> i;
    t  = $signed({2'b00, ATAN_TURN[i]});
    n.flip = l.flip;
    if (!l.z[CW-1]) begin
      n.x = l.x - dx;
      n.y = l.y + dy;
      n.z = l.z - t;
    end else begin
      n.x = l.x + dx;
      n.y = l.y - dy;
      n.z = l.z + t;
    end
    return n;
  endfunction

  // q60 to q30, ties toward plus infinity
  function automatic cw_t round_q30(prod_t p);
    prod_t r;
    r = (p + (prod_t'(1) <<< 29)) >>> 30;
    return CW'(r);
  endfunction

  // q60 to entry format, round, saturate to plus or minus one
  function automatic entry_t to_entry(prod_t v);
    prod_t r;
    prod_t one;
    r   = (v + (prod_t'(1) <<< (59 - ENTRY_FRAC_BITS))) >>> (60 - ENTRY_FRAC_BITS);
    one = prod_t'(1) <<< ENTRY_FRAC_BITS;
    if (r > one) begin
      r = one;
    end else if (r < -one) begin
      r = -one;
    end
    return ENTRY_BITS'(r);
  endfunction

endpackage

// ===== rtl/erm_angles_if.sv =====
interface erm_angles_if;
  logic            valid;
  logic            ready;
  erm_pkg::angle_t yaw_angle;
  erm_pkg::angle_t pitch_angle;
  erm_pkg::angle_t roll_angle;

  modport source (output valid, yaw_angle, pitch_angle, roll_angle, input ready);
  modport sink (input valid, yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

// ===== rtl/erm_matrix_if.sv =====
interface erm_matrix_if;
  logic            valid;
  logic            ready;
  erm_pkg::entry_t m_c1_x;
  erm_pkg::entry_t m_c1_y;
  erm_pkg::entry_t m_c1_z;
  erm_pkg::entry_t m_c2_x;
  erm_pkg::entry_t m_c2_y;
  erm_pkg::entry_t m_c2_z;
  erm_pkg::entry_t m_c3_x;
  erm_pkg::entry_t m_c3_y;
  erm_pkg::entry_t m_c3_z;

  modport source (output valid, m_c1_x, m_c1_y, m_c1_z, m_c2_x, m_c2_y, m_c2_z,
                  m_c3_x, m_c3_y, m_c3_z, input ready);
  modport sink (input valid, m_c1_x, m_c1_y, m_c1_z, m_c2_x, m_c2_y, m_c2_z,
                m_c3_x, m_c3_y, m_c3_z, output ready);
endinterface

// ===== rtl/erm_cordic.sv =====
module erm_cordic (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  erm_pkg::angle_t                        angle_i [erm_pkg::LANES],
  output logic                                   valid_o,
  output erm_pkg::sincos_t                       sc_o [erm_pkg::LANES]
);

  erm_pkg::lane_t   st_q    [erm_pkg::CORDIC_STEPS+1][erm_pkg::LANES];
  logic             valid_q [erm_pkg::CORDIC_STEPS+2];
  erm_pkg::sincos_t sc_q    [erm_pkg::LANES];

  // valid chain, one bit for the fold register, one per step and one for the fold-back register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < erm_pkg::CORDIC_STEPS + 2; k++) valid_q[k] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
      for (int k = 0; k < erm_pkg::CORDIC_STEPS + 1; k++) valid_q[k+1] <= valid_q[k];
    end
  end

  for (genvar l = 0; l < erm_pkg::LANES; l++) begin : g_lane
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[0][l] <= erm_pkg::cordic_init(angle_i[l]);
      end
    end

    for (genvar i = 0; i < erm_pkg::CORDIC_STEPS; i++) begin : g_step
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_q[i+1][l] <= erm_pkg::cordic_step(st_q[i][l], i);
        end
      end
    end

    // undo the half-turn fold
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sc_q[l].s <= st_q[erm_pkg::CORDIC_STEPS][l].flip ?
                     -st_q[erm_pkg::CORDIC_STEPS][l].y : st_q[erm_pkg::CORDIC_STEPS][l].y;
        sc_q[l].c <= st_q[erm_pkg::CORDIC_STEPS][l].flip ?
                     -st_q[erm_pkg::CORDIC_STEPS][l].x : st_q[erm_pkg::CORDIC_STEPS][l].x;
      end
    end
    assign sc_o[l] = sc_q[l];
  end

  assign valid_o = valid_q[erm_pkg::CORDIC_STEPS+1];

endmodule

// ===== rtl/erm_product.sv =====
module erm_product (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   en_i,
  input  logic                                   valid_i,
  input  erm_pkg::sincos_t                       sc_i [erm_pkg::LANES],
  output logic                                   valid_o,
  output erm_pkg::prod_t                         sum_o [erm_pkg::ENTRIES]
);

  logic [3:0] valid_q;

  // stage one: two-factor products
  erm_pkg::prod_t cacb_q, sacb_q, casb_q, sasb_q, sacg_q, cacg_q, sasg_q, casg_q;
  erm_pkg::prod_t cbsg_q, cbcg_q;
  erm_pkg::cw_t   sb1_q, sg1_q, cg1_q;
  // stage two: bracketed pair back to q30
  erm_pkg::prod_t cacb2_q, sacb2_q, sacg2_q, cacg2_q, sasg2_q, casg2_q, cbsg2_q, cbcg2_q;
  erm_pkg::cw_t   casb2_q, sasb2_q, sb2_q, sg2_q, cg2_q;
  // stage three: three-factor products
  erm_pkg::prod_t cacb3_q, sacb3_q, sacg3_q, cacg3_q, sasg3_q, casg3_q, cbsg3_q, cbcg3_q;
  erm_pkg::prod_t t1_q, t2_q, t3_q, t4_q;
  erm_pkg::cw_t   sb3_q;
  // stage four: sums
  erm_pkg::prod_t sum_q [erm_pkg::ENTRIES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cacb_q <= erm_pkg::PW'(sc_i[0].c * sc_i[1].c);
      sacb_q <= erm_pkg::PW'(sc_i[0].s * sc_i[1].c);
      casb_q <= erm_pkg::PW'(sc_i[0].c * sc_i[1].s);
      sasb_q <= erm_pkg::PW'(sc_i[0].s * sc_i[1].s);
      sacg_q <= erm_pkg::PW'(sc_i[0].s * sc_i[2].c);
      cacg_q <= erm_pkg::PW'(sc_i[0].c * sc_i[2].c);
      sasg_q <= erm_pkg::PW'(sc_i[0].s * sc_i[2].s);
      casg_q <= erm_pkg::PW'(sc_i[0].c * sc_i[2].s);
      cbsg_q <= erm_pkg::PW'(sc_i[1].c * sc_i[2].s);
      cbcg_q <= erm_pkg::PW'(sc_i[1].c * sc_i[2].c);
      sb1_q  <= sc_i[1].s;
      sg1_q  <= sc_i[2].s;
      cg1_q  <= sc_i[2].c;

      casb2_q <= erm_pkg::round_q30(casb_q);
      sasb2_q <= erm_pkg::round_q30(sasb_q);
      cacb2_q <= cacb_q;
      sacb2_q <= sacb_q;
      sacg2_q <= sacg_q;
      cacg2_q <= cacg_q;
      sasg2_q <= sasg_q;
      casg2_q <= casg_q;
      cbsg2_q <= cbsg_q;
      cbcg2_q <= cbcg_q;
      sb2_q   <= sb1_q;
      sg2_q   <= sg1_q;
      cg2_q   <= cg1_q;

      t1_q    <= erm_pkg::PW'(casb2_q * sg2_q);
      t2_q    <= erm_pkg::PW'(sasb2_q * sg2_q);
      t3_q    <= erm_pkg::PW'(casb2_q * cg2_q);
      t4_q    <= erm_pkg::PW'(sasb2_q * cg2_q);
      cacb3_q <= cacb2_q;
      sacb3_q <= sacb2_q;
      sacg3_q <= sacg2_q;
      cacg3_q <= cacg2_q;
      sasg3_q <= sasg2_q;
      casg3_q <= casg2_q;
      cbsg3_q <= cbsg2_q;
      cbcg3_q <= cbcg2_q;
      sb3_q   <= sb2_q;

      sum_q[0] <= cacb3_q;
      sum_q[1] <= sacb3_q;
      sum_q[2] <= -(erm_pkg::PW'(sb3_q) <<< 30);
      sum_q[3] <= t1_q - sacg3_q;
      sum_q[4] <= t2_q + cacg3_q;
      sum_q[5] <= cbsg3_q;
      sum_q[6] <= t3_q + sasg3_q;
      sum_q[7] <= t4_q - casg3_q;
      sum_q[8] <= cbcg3_q;
    end
  end

  assign valid_o = valid_q[3];
  assign sum_o   = sum_q;

endmodule

// ===== rtl/euler_zyx_rotation_matrix.sv =====
// ZYX Euler rotation matrix, fully pipelined: takes one angle triple (yaw,
// pitch, roll as 16-bit binary angles, a full turn is 2^ANGLE_BITS) per clock
// and returns the nine entries of Rz(yaw)*Ry(pitch)*Rx(roll) as signed Q2.14,
// rounded to nearest (ties up) and clamped to plus or minus one. The pipe is
// 37 register stages deep: one fold stage, 30 CORDIC steps and a sign-restore
// stage for sine/cosine, four multiply/round/sum stages, and the output
// register that rounds and saturates. Throughput is one item per clock;
// the whole pipe holds while the output register is full and not taken, so
// ready follows the sink's ready whenever a result is waiting.
module euler_zyx_rotation_matrix (
  input  logic           clk_i,
  input  logic           rst_ni,
  erm_angles_if.sink     in_i,
  erm_matrix_if.source   out_o
);

  logic                 en;
  logic                 cordic_valid;
  erm_pkg::angle_t      angles [erm_pkg::LANES];
  erm_pkg::sincos_t     sc [erm_pkg::LANES];
  logic                 prod_valid;
  erm_pkg::prod_t       sums [erm_pkg::ENTRIES];
  logic                 out_valid_q;
  erm_pkg::entry_t      ent_q [erm_pkg::ENTRIES];

  // whole pipe advances unless a finished item sits unread
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign angles[0] = in_i.yaw_angle;
  assign angles[1] = in_i.pitch_angle;
  assign angles[2] = in_i.roll_angle;

  // sine and cosine of all three angles
  erm_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .angle_i (angles),
    .valid_o (cordic_valid),
    .sc_o    (sc)
  );

  // matrix entries in q60
  erm_product u_product (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cordic_valid),
    .sc_i    (sc),
    .valid_o (prod_valid),
    .sum_o   (sums)
  );

  // output register: round, saturate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= prod_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < erm_pkg::ENTRIES; k++) ent_q[k] <= erm_pkg::to_entry(sums[k]);
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.m_c1_x = ent_q[0];
  assign out_o.m_c1_y = ent_q[1];
  assign out_o.m_c1_z = ent_q[2];
  assign out_o.m_c2_x = ent_q[3];
  assign out_o.m_c2_y = ent_q[4];
  assign out_o.m_c2_z = ent_q[5];
  assign out_o.m_c3_x = ent_q[6];
  assign out_o.m_c3_y = ent_q[7];
  assign out_o.m_c3_z = ent_q[8];

endmodule

// ===== bench/tb_euler_zyx_rotation_matrix.sv =====
module tb_euler_zyx_rotation_matrix;

  // one expected matrix, entries in column order
  typedef struct {
    erm_pkg::entry_t e [erm_pkg::ENTRIES];
  } matrix_t;

  // one row of the directed table; known marks a typed-in result
  typedef struct {
    erm_pkg::angle_t  yaw;
    erm_pkg::angle_t  pitch;
    erm_pkg::angle_t  roll;
    bit               known;
    erm_pkg::entry_t  m [erm_pkg::ENTRIES];
  } angle_row_t;

  localparam int RANDOM_ITEMS = 1900;
  localparam int DRAIN_CYCLES = 80;   // covers the 37-stage pipe with margin

  logic clk_i;
  logic rst_ni;

  erm_angles_if angles_if ();
  erm_matrix_if matrix_if ();

  euler_zyx_rotation_matrix u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (angles_if),
    .out_o  (matrix_if)
  );

  matrix_t pending_matrices [$];
  int      mismatch_count;
  bit      sender_done;
  bit      calm_phase;       // long stretch without idling on either side

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // arithmetic shift by s of a signed 64-bit value (floor)
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // sine and cosine in q30 of one binary angle, 30-step cordic after a half-turn fold
  function automatic void angle_sincos(erm_pkg::angle_t raw, output longint s,
                                       output longint c);
    logic [31:0] turn;
    bit          flip;
    longint      x, y, z, dx, dy;
    turn = 32'(raw) << (32 - erm_pkg::ANGLE_BITS);
    flip = (turn[31:30] == 2'b01) || (turn[31:30] == 2'b10);
    if (flip) begin
      turn = turn - 32'h80000000;
    end
    z = longint'($signed(turn));
    x = 64'd652032874;
    y = 0;
    for (int i = 0; i < erm_pkg::CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(erm_pkg::ATAN_TURN[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(erm_pkg::ATAN_TURN[i]);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  // q60 to the entry format: round half up, clamp to plus or minus one
  function automatic erm_pkg::entry_t q60_to_entry(longint v);
    longint r;
    longint one;
    one = longint'(1) <<< erm_pkg::ENTRY_FRAC_BITS;
    r   = floor_shift(v + (longint'(1) <<< (59 - erm_pkg::ENTRY_FRAC_BITS)),
                      60 - erm_pkg::ENTRY_FRAC_BITS);
    if (r > one) r = one;
    if (r < -one) r = -one;
    return erm_pkg::entry_t'(r);
  endfunction

  // expected rotation matrix for one angle triple
  function automatic matrix_t zyx_matrix(erm_pkg::angle_t yaw, erm_pkg::angle_t pitch,
                                         erm_pkg::angle_t roll);
    longint  sa, ca, sb, cb, sg, cg, casb, sasb;
    matrix_t m;
    angle_sincos(yaw, sa, ca);
    angle_sincos(pitch, sb, cb);
    angle_sincos(roll, sg, cg);
    casb = floor_shift(ca * sb + (longint'(1) <<< 29), 30);
    sasb = floor_shift(sa * sb + (longint'(1) <<< 29), 30);
    m.e[0] = q60_to_entry(ca * cb);
    m.e[1] = q60_to_entry(sa * cb);
    m.e[2] = q60_to_entry(-sb * (longint'(1) <<< 30));
    m.e[3] = q60_to_entry(casb * sg - sa * cg);
    m.e[4] = q60_to_entry(sasb * sg + ca * cg);
    m.e[5] = q60_to_entry(cb * sg);
    m.e[6] = q60_to_entry(casb * cg + sa * sg);
    m.e[7] = q60_to_entry(sasb * cg - ca * sg);
    m.e[8] = q60_to_entry(cb * cg);
    return m;
  endfunction

  function automatic angle_row_t plain_row(erm_pkg::angle_t y, erm_pkg::angle_t p,
                                           erm_pkg::angle_t r);
    angle_row_t row;
    row.yaw = y; row.pitch = p; row.roll = r; row.known = 1'b0;
    foreach (row.m[i]) row.m[i] = '0;
    return row;
  endfunction

  // directed rows: zero angles and a half turn of yaw carry typed-in exact matrices,
  // the rest, quarter turns and extremes, are checked by the predictor
  angle_row_t directed_rows [$];

  initial begin
    angle_row_t row;
    // identity at zero angles
    row = plain_row(16'h0000, 16'h0000, 16'h0000);
    row.known = 1'b1;
    row.m = '{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384};
    directed_rows.push_back(row);
    // half turn of yaw: x and y flip, the fold case
    row = plain_row(16'h8000, 16'h0000, 16'h0000);
    row.known = 1'b1;
    row.m = '{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0, 16'sd16384};
    directed_rows.push_back(row);
    directed_rows.push_back(plain_row(16'h4000, 16'h0000, 16'h0000));
    directed_rows.push_back(plain_row(16'h0000, 16'h4000, 16'h0000));
    directed_rows.push_back(plain_row(16'h0000, 16'hC000, 16'h0000));
    directed_rows.push_back(plain_row(16'h0000, 16'h0000, 16'h4000));
    directed_rows.push_back(plain_row(16'hFFFF, 16'hFFFF, 16'hFFFF));
    directed_rows.push_back(plain_row(16'h0001, 16'h0001, 16'h0001));
    directed_rows.push_back(plain_row(16'h7FFF, 16'h8001, 16'h3FFF));
    directed_rows.push_back(plain_row(16'hBFFF, 16'hC001, 16'h4001));
    directed_rows.push_back(plain_row(16'h2000, 16'h2000, 16'h2000));
    directed_rows.push_back(plain_row(16'hE000, 16'h6000, 16'hA000));
    directed_rows.push_back(plain_row(16'h5555, 16'hAAAA, 16'h5555));
    directed_rows.push_back(plain_row(16'hAAAA, 16'h5555, 16'hAAAA));
  end

  // sender: directed table, then random triples
  task automatic send_triple(erm_pkg::angle_t y, erm_pkg::angle_t p, erm_pkg::angle_t r);
    angles_if.valid       <= 1'b1;
    angles_if.yaw_angle   <= y;
    angles_if.pitch_angle <= p;
    angles_if.roll_angle  <= r;
    @(posedge clk_i);
    while (!angles_if.ready) @(posedge clk_i);
    // item taken at this edge; maybe idle before the next one
    if (!calm_phase && $urandom_range(99) < 35) begin
      angles_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 35);
    end
  endtask

  function automatic erm_pkg::angle_t random_angle();
    case ($urandom_range(9))
      0: return erm_pkg::angle_t'($urandom_range(3)) << 14;        // quarter turns
      1: return (erm_pkg::angle_t'($urandom_range(3)) << 14)
                + erm_pkg::angle_t'($urandom_range(2)) - 1'b1;
      default: return erm_pkg::angle_t'($urandom);
    endcase
  endfunction

  initial begin
    erm_pkg::angle_t y, p, r;
    angles_if.valid       = 1'b0;
    angles_if.yaw_angle   = '0;
    angles_if.pitch_angle = '0;
    angles_if.roll_angle  = '0;
    matrix_if.ready       = 1'b0;
    sender_done           = 1'b0;
    calm_phase            = 1'b0;
    mismatch_count        = 0;
    rst_ni                = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      matrix_t m;
      if (directed_rows[k].known) begin
        m.e = directed_rows[k].m;
      end else begin
        m = zyx_matrix(directed_rows[k].yaw, directed_rows[k].pitch, directed_rows[k].roll);
      end
      pending_matrices.push_back(m);
      send_triple(directed_rows[k].yaw, directed_rows[k].pitch, directed_rows[k].roll);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch in the middle runs with no idling at all
      calm_phase = (n >= 800) && (n < 1100);
      y = random_angle();
      p = random_angle();
      r = random_angle();
      pending_matrices.push_back(zyx_matrix(y, p, r));
      send_triple(y, p, r);
    end
    angles_if.valid <= 1'b0;
    sender_done = 1'b1;
  end

  // receiver: random stalls, compare each accepted matrix with the oldest expectation
  always @(posedge clk_i) begin
    matrix_t got;
    matrix_t want;
    if (rst_ni && matrix_if.valid && matrix_if.ready) begin
      got.e = '{matrix_if.m_c1_x, matrix_if.m_c1_y, matrix_if.m_c1_z,
                matrix_if.m_c2_x, matrix_if.m_c2_y, matrix_if.m_c2_z,
                matrix_if.m_c3_x, matrix_if.m_c3_y, matrix_if.m_c3_z};
      if (pending_matrices.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected matrix at %0t", $realtime);
      end else begin
        want = pending_matrices.pop_front();
        for (int i = 0; i < erm_pkg::ENTRIES; i++) begin
          if (got.e[i] !== want.e[i]) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("entry %0d mismatch: expected %0d, got %0d", i, want.e[i], got.e[i]);
            end
          end
        end
      end
    end
    if (rst_ni) begin
      matrix_if.ready <= calm_phase || ($urandom_range(99) >= 35);
    end
  end

  // end of run: drain, then wait for stray results before the verdict
  initial begin
    wait (sender_done);
    while (pending_matrices.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_matrices.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== euler_zyx_rotation_matrix.f =====
rtl/erm_pkg.sv
rtl/erm_angles_if.sv
rtl/erm_matrix_if.sv
rtl/erm_cordic.sv
rtl/erm_product.sv
rtl/euler_zyx_rotation_matrix.sv
bench/tb_euler_zyx_rotation_matrix.sv
